// ===== rtl/mmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared constants and types for the per-channel min/max contrast stretch.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int MAX_CHANNELS = 3;
  localparam int DATA_W       = 8;
  localparam int CH_W         = 2;
  localparam int CNT_W        = 2;
  localparam int FIFO_DEPTH   = 2;
  localparam int PTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int DIV_STEPS    = DATA_W;
  localparam int STEP_W       = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0]  CHAN_COUNT_RST = CNT_W'(3);
  localparam logic [DATA_W-1:0] PIX_MAX        = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] PIX_MIN        = '0;

  localparam logic MODE_STATS = 1'b0;
  localparam logic MODE_NORM  = 1'b1;

  // normalize-pass work item, statistics captured at accept time
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [CH_W-1:0]   chan;
  } item_t;

endpackage

// ===== rtl/min_max_contrast_stretch_top.sv =====
// Path: a normalize sample goes through the queue, the divider and the output
//   register; one that clamps or whose channel is flat skips divider steps.
// Throughput: one normalize sample at a time in the shared 8-step restoring
//   divider; one statistics sample per cycle unless the queue is full.
// Reset: asynchronous, clears min to 255, max to 0, channel count to 3, and
//   empties the queue; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_top
// Per-channel min/max contrast stretch of an interleaved 8-bit image stream.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mmcs_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [mmcs_pkg::DATA_W-1:0] sample_i,
  input  logic                        first_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mmcs_pkg::DATA_W-1:0] stretched_o,
  output logic [mmcs_pkg::CH_W-1:0]   channel_o
);
  import mmcs_pkg::*;

  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  mmcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .first_i     (first_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  mmcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  mmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stretched_o (stretched_o),
    .channel_o   (channel_o)
  );

endmodule

// ===== rtl/mmcs_front.sv =====
// ----------------------------------------------------------------------------
// mmcs_front
// Accepts samples, rotates the channel index, keeps per-channel min/max and
// queues normalize-pass samples with the statistics of their channel.
// ----------------------------------------------------------------------------
module mmcs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mmcs_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [mmcs_pkg::DATA_W-1:0] sample_i,
  input  logic                       first_i,
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output mmcs_pkg::item_t            item_o
);
  import mmcs_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [CH_W-1:0]   idx_q, idx_d;
  logic [DATA_W-1:0] min_q [MAX_CHANNELS];
  logic [DATA_W-1:0] max_q [MAX_CHANNELS];
  logic [DATA_W-1:0] min_d [MAX_CHANNELS];
  logic [DATA_W-1:0] max_d [MAX_CHANNELS];
  logic [CNT_W:0]    n_act;
  logic [CH_W-1:0]   ch_raw, ch;
  logic [CH_W:0]     ch_inc;
  logic              accept;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    n_act = {1'b0, count_q};
    if (count_q == '0) n_act = (CNT_W+1)'(1);
    if (n_act > (CNT_W+1)'(MAX_CHANNELS)) n_act = (CNT_W+1)'(MAX_CHANNELS);
    ch_raw = first_i ? '0 : idx_q;
    // stale index after a count change wraps to channel 0
    ch     = ({1'b0, ch_raw} >= (CH_W+1)'(n_act)) ? '0 : ch_raw;
    ch_inc = {1'b0, ch} + (CH_W+1)'(1);
    idx_d  = (ch_inc >= (CH_W+1)'(n_act)) ? '0 : ch_inc[CH_W-1:0];
  end

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      min_d[k] = (first_i && mode_i == MODE_STATS) ? PIX_MAX : min_q[k];
      max_d[k] = (first_i && mode_i == MODE_STATS) ? PIX_MIN : max_q[k];
      if (ch == CH_W'(k)) begin
        if (sample_i < min_d[k]) min_d[k] = sample_i;
        if (sample_i > max_d[k]) max_d[k] = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CHAN_COUNT_RST;
      idx_q   <= '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        min_q[k] <= PIX_MAX;
        max_q[k] <= PIX_MIN;
      end
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (accept) begin
        idx_q <= idx_d;
        if (mode_i == MODE_STATS) begin
          for (int k = 0; k < MAX_CHANNELS; k++) begin
            min_q[k] <= min_d[k];
            max_q[k] <= max_d[k];
          end
        end
      end
    end
  end

  assign push_o        = accept & (mode_i == MODE_NORM);
  assign item_o.sample = sample_i;
  assign item_o.lo     = min_q[ch[CH_W-1:0]];
  assign item_o.hi     = max_q[ch[CH_W-1:0]];
  assign item_o.chan   = ch;

endmodule

// ===== rtl/mmcs_fifo.sv =====
// ----------------------------------------------------------------------------
// mmcs_fifo
// Short queue of normalize work items between the front and the divider.
// ----------------------------------------------------------------------------
module mmcs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mmcs_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mmcs_pkg::item_t item_o
);
  import mmcs_pkg::*;

  item_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + (PTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (PTR_W+1)'(1);
    end
  end

endmodule

// ===== rtl/mmcs_back.sv =====
// ----------------------------------------------------------------------------
// mmcs_back
// Computes floor((s-lo)*255/(hi-lo)) with a restoring divider, one quotient
// bit per cycle; clamps to 0 or 255; holds the result in an output register.
// ----------------------------------------------------------------------------
module mmcs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  mmcs_pkg::item_t             item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mmcs_pkg::DATA_W-1:0] stretched_o,
  output logic [mmcs_pkg::CH_W-1:0]   channel_o
);
  import mmcs_pkg::*;

  logic                busy_q;
  logic [STEP_W-1:0]   steps_q;
  logic [DATA_W-1:0]   rem_q, num_lo_q, range_q, quo_q;
  logic [CH_W-1:0]     chan_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   stretched_q;
  logic [CH_W-1:0]     channel_q;

  logic [DATA_W-1:0]   diff;
  logic [2*DATA_W-1:0] num;
  logic                flat, below, above;
  logic [DATA_W:0]     trial;
  logic                fits;
  logic                done;

  always_comb begin
    diff  = item_i.sample - item_i.lo;
    num   = {diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, diff};  // diff * 255
    flat  = (item_i.hi <= item_i.lo);
    below = (item_i.sample <= item_i.lo);
    above = (item_i.sample >= item_i.hi);
    trial = {rem_q, num_lo_q[DATA_W-1]};
    fits  = (trial >= {1'b0, range_q});
  end

  assign pop_o = ~busy_q & ~empty_i;
  assign done  = busy_q & (steps_q == '0) & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      if (pop_o) begin
        busy_q  <= 1'b1;
        steps_q <= (flat || below || above) ? '0 : STEP_W'(DIV_STEPS);
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && steps_q != '0) begin
        steps_q <= steps_q - STEP_W'(1);
      end
    end
  end

  // upper byte of the numerator is below the range, so only 8 steps remain
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q    <= num[2*DATA_W-1:DATA_W];
      num_lo_q <= num[DATA_W-1:0];
      range_q  <= item_i.hi - item_i.lo;
      chan_q   <= item_i.chan;
      quo_q    <= (flat || below) ? PIX_MIN : PIX_MAX;
    end else if (busy_q && steps_q != '0) begin
      rem_q    <= fits ? DATA_W'(trial - {1'b0, range_q}) : trial[DATA_W-1:0];
      num_lo_q <= {num_lo_q[DATA_W-2:0], 1'b0};
      quo_q    <= {quo_q[DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      stretched_q <= quo_q;
      channel_q   <= chan_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign stretched_o = stretched_q;
  assign channel_o   = channel_q;

endmodule

// ===== rtl/mmcs_checker.sv =====
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks on the contrast stretch top level, attached by bind.
// ----------------------------------------------------------------------------
module mmcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mmcs_pkg::DATA_W-1:0] stretched_o,
  input logic [mmcs_pkg::CH_W-1:0]   channel_o
);
  import mmcs_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(stretched_o) && $stable(channel_o))
    else $error("result changed while stalled");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_o < CH_W'(MAX_CHANNELS))
    else $error("channel beyond channel limit");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown straight out of reset");

endmodule

bind min_max_contrast_stretch_top mmcs_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .stretched_o (stretched_o),
  .channel_o   (channel_o)
);
